@@ rtl/core/wpm_pkg.sv @@
// Package for the wildcard pattern matcher: command codes, character
// constants, transaction payload types and the letter case fold.
// No dependencies.
`default_nettype none
package wpm_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } wpm_cmd_e;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef struct packed {
    wpm_cmd_e   cmd;
    logic [7:0] data_char;
  } wpm_in_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } wpm_out_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
      r = c - CASE_OFS;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/wpm_closure.sv @@
// Star closure: a '*' at an active position also activates the next one.
// Parallel prefix network over the position vector. Uses no package.
`default_nettype none
module wpm_closure #(
  parameter int unsigned Width = 33
) (
  input  logic [Width-1:0] act_i,
  input  logic [Width-2:0] star_i,
  output logic [Width-1:0] act_o
);

  localparam int unsigned Levels = $clog2(Width);

  logic [Width-1:0] g_lvl [Levels+1];
  logic [Width-1:0] p_lvl [Levels+1];

  always_comb begin
    g_lvl[0] = act_i;
    p_lvl[0] = {star_i, 1'b0};
    for (int lv = 0; lv < Levels; lv++) begin
      for (int j = 0; j < Width; j++) begin
        if (j >= (1 << lv)) begin
          g_lvl[lv+1][j] = g_lvl[lv][j] | (p_lvl[lv][j] & g_lvl[lv][j-(1<<lv)]);
          p_lvl[lv+1][j] = p_lvl[lv][j] & p_lvl[lv][j-(1<<lv)];
        end else begin
          g_lvl[lv+1][j] = g_lvl[lv][j];
          p_lvl[lv+1][j] = p_lvl[lv][j];
        end
      end
    end
    act_o = g_lvl[Levels];
  end

endmodule
`default_nettype wire

@@ rtl/core/wpm_engine.sv @@
// Match engine: pattern store, position flags, active position vector and
// result logic. Depends on wpm_pkg and wpm_closure.
`default_nettype none
module wpm_engine #(
  parameter int unsigned PatternMax = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  wpm_pkg::wpm_in_t  item_i,
  output wpm_pkg::wpm_out_t result_o
);
  import wpm_pkg::*;

  localparam int unsigned N  = PatternMax;
  localparam int unsigned W  = N + 1;
  localparam int unsigned LW = $clog2(N + 1);

  logic [LW-1:0] len_q, len_d;
  logic          ovf_q, ovf_d;
  logic [N-1:0]  used_q, used_d, star_q, star_d, quest_q, quest_d, tab_q, tab_d;
  logic [W-1:0]  act_q, act_d, start_q, start_d;
  logic [7:0]    store_q [N];

  logic [7:0]    c, cf;
  logic          nonzero, full, wr_en;
  logic [N-1:0]  sel, eq, stay, adv;
  logic [N-1:0]  star_n, quest_n, tab_n, used_n;
  logic [W-1:0]  nxt, txt_act, app_start, len_mark, end_v, open_v;

  assign c       = item_i.data_char;
  assign cf      = fold_case(c);
  assign nonzero = (c != CH_NUL);
  assign full    = (len_q == LW'(N));
  assign wr_en   = step_i && (item_i.cmd == CMD_APPEND) && nonzero && !full;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      sel[i] = (len_q == LW'(i));
      eq[i]  = (store_q[i] == cf);
    end
  end

  assign used_n  = used_q | sel;
  assign star_n  = star_q | (sel & {N{c == CH_STAR}});
  assign quest_n = quest_q | (sel & {N{c == CH_QUEST}});
  assign tab_n   = tab_q | (sel & {N{c == CH_TAB}});

  assign stay = act_q[N-1:0] & star_q;
  assign adv  = act_q[N-1:0] & used_q & ~tab_q & ~star_q & (quest_q | eq);
  assign nxt  = {1'b0, stay} | {adv, 1'b0};

  wpm_closure #(.Width(W)) u_text_closure (
    .act_i  (nxt),
    .star_i (star_q),
    .act_o  (txt_act)
  );

  wpm_closure #(.Width(W)) u_start_closure (
    .act_i  ({tab_n, 1'b1}),
    .star_i (star_n),
    .act_o  (app_start)
  );

  assign len_mark = {used_q, 1'b1} & ~{1'b0, used_q};
  assign end_v    = {1'b0, tab_q} | len_mark;
  assign open_v   = ~{tab_q, 1'b1};

  assign result_o.matched          = |(act_q & end_v & open_v);
  assign result_o.pattern_overflow = ovf_q;

  always_comb begin
    len_d   = len_q;
    ovf_d   = ovf_q;
    used_d  = used_q;
    star_d  = star_q;
    quest_d = quest_q;
    tab_d   = tab_q;
    act_d   = act_q;
    start_d = start_q;
    if (step_i) begin
      case (item_i.cmd)
        CMD_CLEAR: begin
          len_d   = '0;
          ovf_d   = 1'b0;
          used_d  = '0;
          star_d  = '0;
          quest_d = '0;
          tab_d   = '0;
          act_d   = W'(1);
          start_d = W'(1);
        end
        CMD_APPEND: begin
          if (nonzero) begin
            if (full) begin
              ovf_d = 1'b1;
              act_d = start_q;
            end else begin
              len_d   = len_q + LW'(1);
              used_d  = used_n;
              star_d  = star_n;
              quest_d = quest_n;
              tab_d   = tab_n;
              act_d   = app_start;
              start_d = app_start;
            end
          end
        end
        CMD_TEXT: begin
          if (nonzero) begin
            act_d = txt_act;
          end
        end
        CMD_END: begin
          act_d = start_q;
        end
        default: begin
          act_d = act_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      ovf_q   <= 1'b0;
      used_q  <= '0;
      star_q  <= '0;
      quest_q <= '0;
      tab_q   <= '0;
      act_q   <= W'(1);
      start_q <= W'(1);
    end else begin
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      used_q  <= used_d;
      star_q  <= star_d;
      quest_q <= quest_d;
      tab_q   <= tab_d;
      act_q   <= act_d;
      start_q <= start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N; i++) begin
      if (wr_en && sel[i]) begin
        store_q[i] <= cf;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/wildcard_pattern_matcher.sv @@
// Wildcard pattern matcher top level: input stage, match engine, result register.
// Depends on wpm_pkg and wpm_engine.
//
// Takes one transaction per clock while the input stage is not stalled:
// pattern loads, text bytes and end-of-text items all sustain one item per
// cycle. Each item is registered in the input stage, from where the engine
// updates the active position vector through parallel-prefix star closure
// networks; an end item's result is loaded into the output register when
// the item leaves the input stage. The input stage only stalls when an end
// item meets a full output register that the consumer is not draining.
// PATTERN_MAX sets the pattern store depth; letters compare without regard
// to case.
`default_nettype none
module wildcard_pattern_matcher #(
  parameter int unsigned PATTERN_MAX = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wpm_pkg::wpm_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wpm_pkg::wpm_out_t out_data_o
);
  import wpm_pkg::*;

  logic     stg_valid_q, stg_valid_d;
  wpm_in_t  stg_q;
  logic     stg_fire, stg_end;
  logic     out_valid_q, out_valid_d;
  wpm_out_t out_q, eng_result;

  assign stg_end    = (stg_q.cmd == CMD_END);
  assign stg_fire   = stg_valid_q && (!stg_end || !out_valid_q || out_ready_i);
  assign in_ready_o = !stg_valid_q || stg_fire;

  wpm_engine #(.PatternMax(PATTERN_MAX)) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (stg_fire),
    .item_i   (stg_q),
    .result_o (eng_result)
  );

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (in_valid_i && in_ready_o) begin
      stg_valid_d = 1'b1;
    end else if (stg_fire) begin
      stg_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (stg_fire && stg_end) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stg_q <= in_data_i;
    end
    if (stg_fire && stg_end) begin
      out_q <= eng_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
